// ===== sv/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W  = 32;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } rsp_t;

endpackage

// ===== sv/lkvc_store.sv =====
// Entry storage, parallel key match and recency-rank update of the cache.
module lkvc_store
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             step,
    input  req_t             req,
    input  logic [CAP_W-1:0] cap,
    output rsp_t             rsp
);

    logic [ENTRIES-1:0]              valid_reg, valid_next;
    logic [ENTRIES-1:0][IDX_W-1:0]   rank_reg, rank_next;
    logic [CNT_W-1:0]                occ_reg, occ_next;
    logic [DATA_W-1:0]               key_mem [ENTRIES];
    logic [DATA_W-1:0]               val_mem [ENTRIES];

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] lru_sel;
    logic [ENTRIES-1:0] valid_kept;
    logic [IDX_W-1:0]   found_idx;
    logic [IDX_W-1:0]   slot_idx;
    logic [IDX_W-1:0]   found_rank;
    logic [IDX_W-1:0]   lru_rank;
    logic [CMP_W-1:0]   eff_cap;
    logic               hit;
    logic               is_put;
    logic               full;
    logic               evict;
    logic               has_free;
    logic               insert;

    assign is_put = (req.opcode == OP_PUT);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_mem[i] == req.lookup_key);
        end
    end

    assign hit = |match;

    // lowest matching entry wins
    always_comb
    begin
        found_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found_idx = IDX_W'(i);
            end
        end
    end

    assign found_rank = rank_reg[found_idx];

    always_comb
    begin
        priority if (cap == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap) > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(cap);
        end
    end

    assign full  = (CMP_W'(occ_reg) >= eff_cap);
    assign evict = is_put && !hit && full && (occ_reg != '0);

    // valid ranks are exactly 0..occupancy-1, so the oldest holds occupancy-1
    assign lru_rank = IDX_W'(occ_reg - CNT_W'(1));

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            lru_sel[i] = evict && valid_reg[i] && (rank_reg[i] == lru_rank);
        end
    end

    assign valid_kept = valid_reg & ~lru_sel;
    assign has_free   = ~&valid_kept;
    assign insert     = is_put && !hit && has_free;

    always_comb
    begin
        slot_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_kept[i])
            begin
                slot_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_kept;
        if (insert)
        begin
            valid_next[slot_idx] = 1'b1;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (hit)
            begin
                if (IDX_W'(i) == found_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < found_rank))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            else
            begin
                if (lru_sel[i])
                begin
                    rank_next[i] = '0;
                end
                if (insert)
                begin
                    if (IDX_W'(i) == slot_idx)
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_kept[i])
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
            end
        end
        occ_next = occ_reg - CNT_W'(evict) + CNT_W'(insert);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rank_reg  <= '0;
            occ_reg   <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
            rank_reg  <= '0;
            occ_reg   <= '0;
        end
        else if (step)
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && !clear)
        begin
            if (hit && is_put)
            begin
                val_mem[found_idx] <= req.write_value;
            end
            else if (insert)
            begin
                key_mem[slot_idx] <= req.lookup_key;
                val_mem[slot_idx] <= req.write_value;
            end
        end
    end

    always_comb
    begin
        rsp.hit        = hit;
        rsp.evicted    = evict;
        rsp.read_value = (hit && !is_put) ? val_mem[found_idx] : '1;
    end

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: handshakes, capacity register, pipeline registers.
// Fully associative 16-entry key-value cache with least-recently-used replacement. One request
// word (get or put) is accepted every cycle while results are drained. Its result word is
// valid in the result register once its request has passed through the input register.
// The latency comes from those two registers. The parallel key compare across all entry
// registers and the rank update that follows it are combinational between them. A stalled
// result word holds the next request in the input register, and further requests wait until
// it drains. Every request returns exactly one result: hit, read_value (-1 on a miss and on
// every put) and evicted.
// Writing the capacity register (0 acts as 1, above 16 acts as 16) empties the cache at once;
// write it only while no request is in flight.
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    logic             in_valid_reg;
    req_t             in_data_reg;
    logic             out_valid_reg;
    rsp_t             out_data_reg;
    logic [CAP_W-1:0] cap_reg;
    logic             advance;
    logic             cfg_write;
    rsp_t             rsp_comb;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // request moves on when the result register is empty or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    lkvc_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_write),
        .step  (advance),
        .req   (in_data_reg),
        .cap   (cap_reg),
        .rsp   (rsp_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_data_reg <= req_data;
        end
        if (advance)
        begin
            out_data_reg <= rsp_comb;
        end
    end

endmodule

// ===== tb/tb_lru_key_value_cache.sv =====
// Self-checking testbench for the LRU key-value cache: directed table, then random phases.
module tb_lru_key_value_cache;
    timeunit 1ns;
    timeprecision 1ps;
    import lkvc_pkg::*;

    localparam logic signed [DATA_W-1:0] MISS_VALUE = -1;
    localparam int TIMEOUT_NS = 4_000_000;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        req_t             req;
        logic [CAP_W-1:0] cap;
        bit               pinned;  // expected word typed into the table
        rsp_t             want;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    req_t             req_data;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_t             rsp_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    // shadow copy of the cache contents
    logic [DATA_W-1:0] shadow_key [ENTRIES];
    logic [DATA_W-1:0] shadow_val [ENTRIES];
    bit                shadow_used [ENTRIES];
    int                shadow_age [ENTRIES];
    int                shadow_count;
    logic [CAP_W-1:0]  shadow_cap;

    rsp_t      pending_rsp [$];
    stim_row_t stim_rows [$];

    bit idle_on;
    int mismatches;
    int req_count;
    int rsp_count;
    int hit_count;
    int evict_count;
    int cap_writes;

    lru_key_value_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void clear_shadow(input logic [CAP_W-1:0] cap);
        int i;
        for (i = 0; i < ENTRIES; i++)
        begin
            shadow_used[i] = 1'b0;
            shadow_age[i]  = 0;
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
        end
        shadow_count = 0;
        shadow_cap   = cap;
    endfunction

    // Applies one request to the shadow cache and returns the word it should produce.
    function automatic rsp_t cache_lookup(input req_t r);
        rsp_t res;
        int   i;
        int   hit_at;
        int   lru;
        int   lru_age;
        int   slot;
        int   limit;
        int   age;
        res.hit        = 1'b0;
        res.read_value = MISS_VALUE;
        res.evicted    = 1'b0;
        hit_at         = -1;
        for (i = 0; i < ENTRIES; i++)
            if (hit_at < 0 && shadow_used[i] && shadow_key[i] == r.lookup_key)
                hit_at = i;
        if (hit_at >= 0)
        begin
            res.hit = 1'b1;
            if (r.opcode == OP_PUT)
                shadow_val[hit_at] = r.write_value;
            else
                res.read_value = shadow_val[hit_at];
            age = shadow_age[hit_at];
            for (i = 0; i < ENTRIES; i++)
                if (shadow_used[i] && i != hit_at && shadow_age[i] < age)
                    shadow_age[i]++;
            shadow_age[hit_at] = 0;
        end
        else if (r.opcode == OP_PUT)
        begin
            limit = (shadow_cap == 0) ? 1 : (shadow_cap > ENTRIES) ? ENTRIES : int'(shadow_cap);
            if (shadow_count >= limit)
            begin
                lru     = -1;
                lru_age = -1;
                for (i = 0; i < ENTRIES; i++)
                    if (shadow_used[i] && shadow_age[i] > lru_age)
                    begin
                        lru     = i;
                        lru_age = shadow_age[i];
                    end
                if (lru >= 0)
                begin
                    shadow_used[lru] = 1'b0;
                    shadow_age[lru]  = 0;
                    shadow_count--;
                    res.evicted = 1'b1;
                end
            end
            slot = -1;
            for (i = 0; i < ENTRIES; i++)
                if (slot < 0 && !shadow_used[i])
                    slot = i;
            if (slot >= 0)
            begin
                for (i = 0; i < ENTRIES; i++)
                    if (shadow_used[i])
                        shadow_age[i]++;
                shadow_key[slot]  = r.lookup_key;
                shadow_val[slot]  = r.write_value;
                shadow_used[slot] = 1'b1;
                shadow_age[slot]  = 0;
                shadow_count++;
            end
        end
        return res;
    endfunction

    function automatic void dir_req(input logic op, input logic [DATA_W-1:0] key,
                                    input logic [DATA_W-1:0] val);
        stim_row_t row;
        row.kind              = ROW_REQ;
        row.req.opcode        = op;
        row.req.lookup_key    = key;
        row.req.write_value   = val;
        row.cap               = '0;
        row.pinned            = 1'b0;
        row.want              = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void dir_chk(input logic op, input logic [DATA_W-1:0] key,
                                    input logic [DATA_W-1:0] val, input logic hit,
                                    input logic [DATA_W-1:0] rd, input logic ev);
        stim_row_t row;
        row.kind              = ROW_REQ;
        row.req.opcode        = op;
        row.req.lookup_key    = key;
        row.req.write_value   = val;
        row.cap               = '0;
        row.pinned            = 1'b1;
        row.want.hit          = hit;
        row.want.read_value   = rd;
        row.want.evicted      = ev;
        stim_rows.push_back(row);
    endfunction

    function automatic void dir_cap(input logic [CAP_W-1:0] cap);
        stim_row_t row;
        row.kind   = ROW_CFG;
        row.req    = '0;
        row.cap    = cap;
        row.pinned = 1'b0;
        row.want   = '0;
        stim_rows.push_back(row);
    endfunction

    // Sends one request word; valid is left high after acceptance.
    task automatic send_req(input req_t r, input bit pinned, input rsp_t want);
        rsp_t predicted;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = cache_lookup(r);
        pending_rsp.push_back(pinned ? want : predicted);
        req_count++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cap(input logic [CAP_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        clear_shadow(cap);
        cap_writes++;
    endtask

    // result side: random stalls, compare each word with the oldest expectation
    initial
    begin
        rsp_t want;
        int   stall;
        stall = 0;
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                rsp_count++;
                if (pending_rsp.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no word, actual hit=%0b read_value=%0d evicted=%0b",
                             $time, rsp_data.hit, rsp_data.read_value, rsp_data.evicted);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    hit_count   += want.hit;
                    evict_count += want.evicted;
                    if (rsp_data.hit !== want.hit)
                    begin
                        mismatches++;
                        $display("%0t: hit expected %0b actual %0b",
                                 $time, want.hit, rsp_data.hit);
                    end
                    if (rsp_data.read_value !== want.read_value)
                    begin
                        mismatches++;
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, rsp_data.read_value);
                    end
                    if (rsp_data.evicted !== want.evicted)
                    begin
                        mismatches++;
                        $display("%0t: evicted expected %0b actual %0b",
                                 $time, want.evicted, rsp_data.evicted);
                    end
                end
            end
            // a burst left over from an idling part does not run into a part without idling
            if (stall > 0 && idle_on)
            begin
                stall--;
                rsp_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 14) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [CAP_W-1:0]  caps [9];
        logic [DATA_W-1:0] key_pool [32];
        logic [CAP_W-1:0]  cap;
        stim_row_t         row;
        req_t              r;
        int                pool_n;
        int                eff;
        int                ph;
        int                n;
        int                k;

        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req_data   <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        idle_on     = 1'b1;
        mismatches  = 0;
        req_count   = 0;
        rsp_count   = 0;
        hit_count   = 0;
        evict_count = 0;
        cap_writes  = 0;
        clear_shadow(CAP_RESET);

        // extremes of key and value, a stored -1, clearing writes, LRU order
        dir_chk(OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS_VALUE, 1'b0);
        dir_chk(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, MISS_VALUE, 1'b0);
        dir_chk(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0);
        dir_chk(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, MISS_VALUE, 1'b0);
        dir_chk(OP_GET, 32'h7FFF_FFFF, 32'h5A5A_A5A5, 1'b1, 32'h8000_0000, 1'b0);
        dir_chk(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, MISS_VALUE, 1'b0);
        dir_chk(OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0);
        dir_cap(5'd16);  // same value as reset, still empties the cache
        dir_chk(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, MISS_VALUE, 1'b0);
        dir_cap(5'd1);
        dir_req(OP_PUT, 32'h0000_0001, 32'h0000_000B);
        dir_req(OP_PUT, 32'h0000_0002, 32'h0000_0016);
        dir_req(OP_GET, 32'h0000_0001, 32'h0000_0000);
        dir_req(OP_GET, 32'h0000_0002, 32'h0000_0000);
        dir_cap(5'd0);   // acts as capacity 1
        dir_req(OP_PUT, 32'h0000_0005, 32'h0000_0005);
        dir_req(OP_PUT, 32'h0000_0006, 32'h0000_0006);
        dir_req(OP_GET, 32'h0000_0005, 32'h0000_0000);
        dir_cap(5'd2);
        dir_req(OP_PUT, 32'h0000_0001, 32'h1111_1111);
        dir_req(OP_PUT, 32'h0000_0002, 32'h2222_2222);
        dir_req(OP_GET, 32'h0000_0001, 32'h0000_0000);
        dir_req(OP_PUT, 32'h0000_0003, 32'h3333_3333);
        dir_req(OP_GET, 32'h0000_0002, 32'h0000_0000);
        dir_req(OP_GET, 32'h0000_0001, 32'h0000_0000);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG)
                write_cap(row.cap);
            else
                send_req(row.req, row.pinned, row.want);
        end

        // 31 saturates to 16, 17 likewise; one phase picks its capacity at random
        caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd8, 5'd16};
        for (ph = 0; ph < 9; ph++)
        begin
            cap = (ph == 7) ? CAP_W'($urandom_range(1, 16)) : caps[ph];
            write_cap(cap);
            eff    = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : int'(cap);
            pool_n = eff + $urandom_range(1, 6);
            for (k = 0; k < pool_n; k++)
                key_pool[k] = $urandom;
            for (n = 0; n < 140; n++)
            begin
                idle_on = (ph != 8) && ((n / 35) % 3 != 2);
                if (ph == 3 && n == 70)
                    drain();
                r.opcode      = $urandom_range(0, 1) ? OP_PUT : OP_GET;
                r.lookup_key  = ($urandom_range(0, 9) == 0)
                                ? $urandom
                                : key_pool[$urandom_range(0, pool_n - 1)];
                r.write_value = $urandom;
                send_req(r, 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests, %0d result words (%0d hits, %0d evictions),",
                 req_count, rsp_count, hit_count, evict_count);
        $display("over %0d capacity writes including 0, 1, 16 and saturating values.",
                 cap_writes);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("Timeout with %0d result words outstanding", pending_rsp.size());
        $display("FAILURE");
        $finish;
    end

endmodule
